// ----- design/pol_pkg.sv -----
package pol_pkg;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_POS   = 3'd1;
    localparam logic [2:0] CMD_INS_END   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_POS   = 3'd4;
    localparam logic [2:0] CMD_DEL_END   = 3'd5;
    localparam logic [2:0] CMD_TRAVERSE  = 3'd6;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOAD,
        CELL_HEAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] data;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_TRAV
    } t_state;

endpackage

// ----- design/positional_ordered_list_top.sv -----
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells,
// cell 0 being the front.
// Command channel: an item (i_cmd, i_value_in, i_position) is taken at a
// rising edge where start is high and busy is low.
// Result channel: each result shows on o_status, o_value_out and o_last for
// one cycle with o_strobe high; the receiver cannot stall it, so results
// are never held back.
// Inserts and deletes: one result, in the cycle after the item is taken; all
// cells shift together in that same cycle, so a new item can follow in the
// next cycle.
// Traverse: the occupied cells rotate toward the front once per cycle and
// cell 0 is emitted; the first result shows once r_state has entered
// ST_TRAV and r_value has captured cell 0, and the rest follow one per cycle,
// count results in all. busy is high in ST_TRAV and drops as the last
// result shows. An empty traverse gives its one result in the next cycle.
// Command code seven gives no result. Throughput is one item per cycle,
// but a traverse of a non-empty list holds busy high until its last
// result shows.
// Reset empties the list; cell contents are not cleared, only the count.
module positional_ordered_list_top
    import pol_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value_in,
    input  logic [4:0]         i_position,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic               o_last
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_left;
    logic [CNT_W-1:0]  n_left;
    logic              r_strobe;
    logic              n_strobe;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              r_last;
    logic              n_last;

    logic [DATA_W-1:0] w_cells [DEPTH];
    t_cell_ctl         w_ctl   [DEPTH];

    logic              accept;
    logic              is_ins;
    logic              is_del;
    logic              is_trav;
    logic              full;
    logic              empty;
    logic              pos_ok_ins;
    logic              pos_ok_del;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  tail;
    logic              do_ins;
    logic              do_del;
    logic              do_rot;

    assign busy   = (r_state == ST_TRAV);
    assign accept = start && !busy;

    assign is_ins  = i_cmd inside {CMD_INS_FRONT, CMD_INS_POS, CMD_INS_END};
    assign is_del  = i_cmd inside {CMD_DEL_FRONT, CMD_DEL_POS, CMD_DEL_END};
    assign is_trav = (i_cmd == CMD_TRAVERSE);

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);
    assign pos_x = CMP_W'(i_position);
    assign cnt_x = CMP_W'(r_count);
    assign tail  = r_count - CNT_W'(1);

    assign pos_ok_ins = (i_position != '0) && (pos_x <= cnt_x + CMP_W'(1));
    assign pos_ok_del = (i_position != '0) && (pos_x <= cnt_x);

    always_comb begin
        case (i_cmd)
            CMD_INS_END: idx = r_count;
            CMD_DEL_END: idx = tail;
            CMD_INS_POS,
            CMD_DEL_POS: idx = CNT_W'(pos_x - CMP_W'(1));
            default:     idx = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_trav && !empty) begin
                    n_state = ST_TRAV;
                end
            end
            ST_TRAV: begin
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and cell control
    always_comb begin
        n_count  = r_count;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_status = STAT_OK;
        n_value  = '0;
        n_last   = 1'b0;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_rot   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_ins) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    if (full) begin
                        n_status = STAT_FULL;
                    end else if (i_cmd == CMD_INS_POS && !pos_ok_ins) begin
                        n_status = STAT_RANGE;
                    end else begin
                        do_ins  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (accept && is_del) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    if (empty) begin
                        n_status = STAT_EMPTY;
                    end else if (i_cmd == CMD_DEL_POS && !pos_ok_del) begin
                        n_status = STAT_RANGE;
                    end else begin
                        do_del  = 1'b1;
                        n_value = w_cells[idx[IDX_W-1:0]];
                        n_count = tail;
                    end
                end else if (accept && is_trav) begin
                    if (empty) begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        n_status = STAT_EMPTY;
                    end else begin
                        n_left = r_count;
                    end
                end
            end
            ST_TRAV: begin
                n_strobe = 1'b1;
                n_value  = w_cells[0];
                n_last   = (r_left == CNT_W'(1));
                n_left   = r_left - CNT_W'(1);
                do_rot   = 1'b1;
            end
            default: ;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] CI = CNT_W'(i);
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cells[i-1];
        end
        if (i == DEPTH - 1) begin : g_lastc
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cells[i+1];
        end

        always_comb begin
            w_ctl[i].data = i_value_in;
            w_ctl[i].op   = CELL_HOLD;
            if (do_ins) begin
                if (CI > idx) begin
                    w_ctl[i].op = CELL_LEFT;
                end else if (CI == idx) begin
                    w_ctl[i].op = CELL_LOAD;
                end
            end else if (do_del) begin
                if (CI >= idx && i != DEPTH - 1) begin
                    w_ctl[i].op = CELL_RIGHT;
                end
            end else if (do_rot) begin
                if (CI < tail) begin
                    w_ctl[i].op = CELL_RIGHT;
                end else if (CI == tail) begin
                    w_ctl[i].op = CELL_HEAD;
                end
            end
        end

        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cells[0]),
            .o_value (w_cells[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_last      = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("list count beyond depth");

    a_trav_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TRAV |=> r_strobe && r_status == STAT_OK)
        else $error("traverse cycle without ok result");

    a_trav_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRAV && r_left == CNT_W'(1)) |=> (r_state == ST_IDLE && r_last))
        else $error("traverse did not close with last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != STAT_OK) |-> (r_value == '0 && r_last))
        else $error("error result carries data or misses last");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRAV) |=> $stable(r_count))
        else $error("count changed during traverse");

endmodule

// ----- design/pol_cell.sv -----
module pol_cell
    import pol_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    input  logic [DATA_W-1:0] i_head,
    output logic [DATA_W-1:0] o_value
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        case (i_ctl.op)
            CELL_LEFT:  n_value = i_left;
            CELL_RIGHT: n_value = i_right;
            CELL_LOAD:  n_value = i_ctl.data;
            CELL_HEAD:  n_value = i_head;
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import pol_pkg::*;

    localparam int DEPTH          = 16;
    localparam int IDLE_MAX       = 5;
    localparam int RANDOM_ITEMS   = 50;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic               last;
    } t_list_result;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [4:0]  pos;
        logic        rnd_val;
        logic [4:0]  reps;
        logic        typed;
        logic [1:0]  want_status;
    } t_list_cmd_row;

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic [2:0]         i_cmd      = CMD_INS_FRONT;
    logic signed [31:0] i_value_in = '0;
    logic [4:0]         i_position = '0;
    logic               busy;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic signed [31:0] o_value_out;
    logic               o_last;

    logic signed [31:0] shadow_cells [DEPTH];
    int                 shadow_count = 0;
    t_list_result       item_results [$];
    t_list_result       pending_results [$];
    t_list_cmd_row      cmd_table [$];

    int mismatches   = 0;
    int results_seen = 0;
    int items_taken  = 0;
    int full_hits    = 0;
    int empty_hits   = 0;
    int peak_count   = 0;
    int idle_cycles  = 0;

    positional_ordered_list_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_value_in (i_value_in),
        .i_position (i_position),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_value_out(o_value_out),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_list(input logic [2:0] cmd, input logic signed [31:0] val,
                                input logic [4:0] pos);
        t_list_result r;
        int           idx;
        int           i;
        item_results.delete();
        r.status = STAT_OK;
        r.value  = '0;
        r.last   = 1'b1;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_POS, CMD_INS_END: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                    full_hits++;
                end else if (cmd == CMD_INS_POS
                        && (int'(pos) < 1 || int'(pos) > shadow_count + 1)) begin
                    r.status = STAT_RANGE;
                end else begin
                    if (cmd == CMD_INS_FRONT)
                        idx = 0;
                    else if (cmd == CMD_INS_END)
                        idx = shadow_count;
                    else
                        idx = int'(pos) - 1;
                    for (i = shadow_count; i > idx; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[idx] = val;
                    shadow_count++;
                end
                item_results.push_back(r);
            end
            CMD_DEL_FRONT, CMD_DEL_POS, CMD_DEL_END: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                    empty_hits++;
                end else if (cmd == CMD_DEL_POS
                        && (int'(pos) < 1 || int'(pos) > shadow_count)) begin
                    r.status = STAT_RANGE;
                end else begin
                    if (cmd == CMD_DEL_FRONT)
                        idx = 0;
                    else if (cmd == CMD_DEL_END)
                        idx = shadow_count - 1;
                    else
                        idx = int'(pos) - 1;
                    r.value = shadow_cells[idx];
                    for (i = idx; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
                item_results.push_back(r);
            end
            CMD_TRAVERSE: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                    empty_hits++;
                    item_results.push_back(r);
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        r.value = shadow_cells[i];
                        r.last  = (i == shadow_count - 1);
                        item_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endtask

    task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] val,
                             input logic [4:0] pos, input int gap,
                             input logic typed, input logic [1:0] want_status);
        t_list_result r;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_value_in <= val;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
        items_taken++;
        predict_list(cmd, val, pos);
        if (typed) begin
            r.status = want_status;
            r.value  = '0;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end else begin
            foreach (item_results[k])
                pending_results.push_back(item_results[k]);
        end
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] val, input logic [4:0] pos,
                           input logic rnd_val, input int reps,
                           input logic typed, input logic [1:0] want_status);
        t_list_cmd_row row;
        row.cmd         = cmd;
        row.value       = val;
        row.pos         = pos;
        row.rnd_val     = rnd_val;
        row.reps        = reps[4:0];
        row.typed       = typed;
        row.want_status = want_status;
        cmd_table.push_back(row);
    endtask

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result status %0d value %h last %0d",
                             $time, o_status, o_value_out, o_last);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_value_out !== want.value
                        || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch status %0d/%0d value %h/%h last %0d/%0d",
                                 $time, want.status, o_status, want.value, o_value_out,
                                 want.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_list_cmd_row      row;
        logic [2:0]         cmd;
        logic signed [31:0] val;
        logic [4:0]         pos;
        int                 n_random;
        int                 n_directed;
        int                 roll;
        int                 ins_cut;
        int                 gap;

        add_row(CMD_TRAVERSE,  32'h0,        5'd0,  1'b0, 1,  1'b1, STAT_EMPTY);
        add_row(CMD_DEL_FRONT, 32'h0,        5'd0,  1'b0, 1,  1'b1, STAT_EMPTY);
        add_row(CMD_DEL_POS,   32'h0,        5'd1,  1'b0, 1,  1'b1, STAT_EMPTY);
        add_row(CMD_DEL_END,   32'h0,        5'd0,  1'b0, 1,  1'b1, STAT_EMPTY);
        add_row(CMD_INS_POS,   32'h1234,     5'd0,  1'b0, 1,  1'b1, STAT_RANGE);
        add_row(CMD_INS_POS,   32'h1234,     5'd2,  1'b0, 1,  1'b1, STAT_RANGE);
        add_row(CMD_INS_POS,   32'h7FFFFFFF, 5'd1,  1'b0, 1,  1'b1, STAT_OK);
        add_row(CMD_INS_FRONT, 32'h80000000, 5'd0,  1'b0, 1,  1'b1, STAT_OK);
        add_row(CMD_INS_END,   32'hFFFFFFFF, 5'd0,  1'b0, 1,  1'b1, STAT_OK);
        add_row(CMD_INS_POS,   32'h0,        5'd4,  1'b0, 1,  1'b1, STAT_OK);
        add_row(CMD_INS_POS,   32'h5A5A5A5A, 5'd31, 1'b0, 1,  1'b1, STAT_RANGE);
        add_row(CMD_TRAVERSE,  32'h0,        5'd0,  1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_DEL_POS,   32'h0,        5'd0,  1'b0, 1,  1'b1, STAT_RANGE);
        add_row(CMD_DEL_POS,   32'h0,        5'd5,  1'b0, 1,  1'b1, STAT_RANGE);
        add_row(CMD_DEL_POS,   32'h0,        5'd2,  1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_UNUSED,    32'hFFFFFFFF, 5'd31, 1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_DEL_FRONT, 32'h0,        5'd0,  1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_DEL_END,   32'h0,        5'd0,  1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_INS_END,   32'h0,        5'd0,  1'b1, 14, 1'b0, STAT_OK);
        add_row(CMD_INS_POS,   32'h0,        5'd16, 1'b1, 1,  1'b0, STAT_OK);
        add_row(CMD_INS_FRONT, 32'h1,        5'd0,  1'b0, 1,  1'b1, STAT_FULL);
        add_row(CMD_INS_POS,   32'h1,        5'd0,  1'b0, 1,  1'b1, STAT_FULL);
        add_row(CMD_INS_END,   32'h1,        5'd0,  1'b0, 1,  1'b1, STAT_FULL);
        add_row(CMD_TRAVERSE,  32'h0,        5'd0,  1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_DEL_POS,   32'h0,        5'd16, 1'b0, 1,  1'b0, STAT_OK);
        add_row(CMD_DEL_POS,   32'h0,        5'd16, 1'b0, 1,  1'b1, STAT_RANGE);
        add_row(CMD_DEL_FRONT, 32'h0,        5'd0,  1'b0, 10, 1'b0, STAT_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_table[r]) begin
            row = cmd_table[r];
            repeat (row.reps) begin
                val = row.rnd_val ? $urandom : row.value;
                send_item(row.cmd, val, row.pos, $urandom_range(0, IDLE_MAX),
                          row.typed, row.want_status);
            end
        end
        n_directed = items_taken;

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            roll    = $urandom_range(0, 99);
            ins_cut = ((n_random / 25) % 2 == 0) ? 85 : 30;
            if (roll < 4) begin
                cmd = CMD_UNUSED;
            end else if (roll < 14) begin
                cmd = CMD_TRAVERSE;
            end else if ($urandom_range(0, 99) < ins_cut) begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_INS_FRONT;
                    1:       cmd = CMD_INS_POS;
                    default: cmd = CMD_INS_END;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_DEL_FRONT;
                    1:       cmd = CMD_DEL_POS;
                    default: cmd = CMD_DEL_END;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                pos = 5'($urandom_range(0, 31));
            else if (cmd == CMD_DEL_POS && shadow_count > 0)
                pos = 5'($urandom_range(1, shadow_count));
            else
                pos = 5'($urandom_range(1, shadow_count + 1));
            val = $urandom;
            gap = ((n_random / 20) % 3 == 1) ? 0 : $urandom_range(0, IDLE_MAX);
            send_item(cmd, val, pos, gap, 1'b0, STAT_OK);
            if (cmd != CMD_UNUSED)
                n_random++;
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d directed), checked %0d results, %0d mismatches.",
                 items_taken, n_directed, results_seen, mismatches);
        $display("List peaked at %0d of %0d entries; full rejects %0d, empty rejects %0d.",
                 peak_count, DEPTH, full_hits, empty_hits);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
design/pol_pkg.sv
design/pol_cell.sv
design/positional_ordered_list_top.sv
dv/tb.sv
